[design/rspa_pkg.sv]
// package: sizes, request and status codes, payload structs for the slot pool allocator
package rspa_pkg;
  localparam int NumSlots    = 16384;
  localparam int BatchSize   = 1024;
  localparam int StaticSlots = 8;
  localparam int NumBatches  = (NumSlots + BatchSize - 1) / BatchSize;
  localparam int SlotW       = $clog2(NumSlots);
  localparam int LinkW       = SlotW + 1;
  localparam int BatchW      = $clog2(NumBatches);
  localparam int BOffW       = $clog2(BatchSize);
  localparam int BCntW       = BOffW + 1;

  localparam logic [LinkW-1:0] LinkEnd = LinkW'(NumSlots);

  localparam logic [2:0] ReqAlloc  = 3'd0;
  localparam logic [2:0] ReqLookup = 3'd1;
  localparam logic [2:0] ReqRef    = 3'd2;
  localparam logic [2:0] ReqForget = 3'd3;
  localparam logic [2:0] ReqRetire = 3'd4;

  localparam logic [1:0] StDone      = 2'd0;
  localparam logic [1:0] StExhausted = 2'd1;
  localparam logic [1:0] StNotLive   = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [13:0] slot_index;
    logic [31:0] drop_count;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] granted_slot;
    logic        slot_freed;
    logic        release_valid;
    logic [3:0]  release_batch;
  } out_word_t;

  // per-slot record kept in the slot memory
  typedef struct packed {
    logic [LinkW-1:0] link;
    logic [31:0]      count;
    logic             deleted;
    logic             detached;
  } slot_rec_t;
endpackage

[design/refcounted_slot_pool_allocator.sv]
// top level: slot pool allocator sequencer around the slot memory
// One request at a time; busy is high from acceptance until the result word.
// Lookup, ref, forget and retire step through issue, memory read, compute
// and write back, and result; alloc from a non-empty list takes the same
// steps. An alloc on an empty list first grows one batch, writing one slot
// record per cycle, or reports exhausted once the whole pool has grown.
// After reset a clearing pass walks the whole slot memory and then grows
// the first batch with busy held high. The result word is shown for one
// cycle on out_valid and cannot be stalled.
module refcounted_slot_pool_allocator
  import rspa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);
  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SGrow  = 3'd1;
  localparam logic [2:0] SIdle  = 3'd2;
  localparam logic [2:0] SRead  = 3'd3;
  localparam logic [2:0] SExec  = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [SlotW:0]   ptr_r, ptr_nxt;        // clear or grow walk position
  logic [LinkW-1:0] grow_end_r, grow_end_nxt;
  logic             grow_alloc_r, grow_alloc_nxt; // growth on behalf of an alloc
  logic [SlotW-1:0] head_r, head_nxt;      // 0 = empty list
  logic [LinkW-1:0] hw_r, hw_nxt;
  logic [BCntW-1:0] bcnt_r [NumBatches];
  in_word_t         req_r, req_nxt;
  out_word_t        res_r, res_nxt;
  logic             ov_r, ov_nxt;

  logic             we;
  logic [SlotW-1:0] waddr;
  slot_rec_t        wdata;
  logic             re;
  logic [SlotW-1:0] raddr;
  slot_rec_t        rdata;

  // batch counter update, one per cycle at most
  logic             bc_inc, bc_dec;
  logic [BatchW-1:0] bc_idx;

  rspa_slot_mem u_mem (
    .clk, .we, .waddr, .wdata, .re, .raddr, .rdata
  );

  logic [SlotW-1:0] s;
  logic             is_static, alloc_ok, live;
  logic             fr, rel;
  logic [BatchW-1:0] sb;
  logic [LinkW-1:0] push_link;
  logic [BCntW-1:0] cnt_after;

  assign s         = req_r.slot_index;
  assign is_static = (s != '0) && ({1'b0, s} < LinkW'(StaticSlots));
  assign alloc_ok  = (s != '0) && ({1'b0, s} < hw_r) && (rdata.link == '0);
  assign live      = alloc_ok && !rdata.deleted;
  assign push_link = (head_r != '0) ? {1'b0, head_r} : LinkEnd;
  assign sb        = BatchW'(s >> BOffW);
  assign cnt_after = (bcnt_r[sb] < BCntW'(BatchSize)) ? bcnt_r[sb] + 1'b1 : bcnt_r[sb];

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    grow_end_nxt   = grow_end_r;
    grow_alloc_nxt = grow_alloc_r;
    head_nxt       = head_r;
    hw_nxt         = hw_r;
    req_nxt        = req_r;
    res_nxt        = res_r;
    ov_nxt         = 1'b0;
    we             = 1'b0;
    waddr          = SlotW'(ptr_r);
    wdata          = '0;
    re             = 1'b0;
    raddr          = s;
    bc_inc         = 1'b0;
    bc_dec         = 1'b0;
    bc_idx         = BatchW'(ptr_r[SlotW-1:0] >> BOffW);
    fr             = 1'b0;
    rel            = 1'b0;
    case (state_r)
      SClear: begin
        we      = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == (SlotW+1)'(NumSlots - 1)) begin
          state_nxt      = SGrow;
          ptr_nxt        = (SlotW+1)'(StaticSlots);
          grow_end_nxt   = (StaticSlots + BatchSize > NumSlots) ? LinkW'(NumSlots)
                                                                : LinkW'(StaticSlots + BatchSize);
          hw_nxt         = LinkW'(StaticSlots);
          grow_alloc_nxt = 1'b0;
        end
      end
      SGrow: begin
        if ((SlotW+1)'(grow_end_r) == ptr_r) begin
          hw_nxt = grow_end_r;
          if (grow_alloc_r) begin
            re        = 1'b1;
            raddr     = head_r;
            state_nxt = SRead;
          end else begin
            state_nxt = SIdle;
          end
        end else begin
          if (ptr_r[SlotW-1:0] != '0) begin
            we         = 1'b1;
            wdata.link = push_link;
            bc_inc     = 1'b1;
            head_nxt   = ptr_r[SlotW-1:0];
          end
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      SIdle: begin
        if (start) begin
          req_nxt = in_word;
          if (in_word.req_type == ReqAlloc) begin
            if (head_r == '0) begin
              if (hw_r >= LinkW'(NumSlots)) begin
                res_nxt   = '{status: StExhausted, default: '0};
                ov_nxt    = 1'b1;
                state_nxt = SOut;
              end else begin
                state_nxt      = SGrow;
                ptr_nxt        = hw_r;
                grow_end_nxt   = (hw_r + LinkW'(BatchSize) > LinkW'(NumSlots))
                                 ? LinkW'(NumSlots) : hw_r + LinkW'(BatchSize);
                grow_alloc_nxt = 1'b1;
              end
            end else begin
              re        = 1'b1;
              raddr     = head_r;
              state_nxt = SRead;
            end
          end else begin
            re        = 1'b1;
            raddr     = in_word.slot_index;
            state_nxt = SRead;
          end
        end
      end
      SRead: begin
        state_nxt = SExec;
      end
      SExec: begin
        res_nxt = '{status: StDone, granted_slot: s, default: '0};
        case (req_r.req_type)
          ReqAlloc: begin
            if (head_r == '0) begin
              res_nxt.status       = StExhausted;
              res_nxt.granted_slot = '0;
            end else begin
              head_nxt  = (rdata.link == LinkEnd || rdata.link >= LinkW'(NumSlots))
                          ? '0 : SlotW'(rdata.link);
              we        = 1'b1;
              waddr     = head_r;
              bc_dec    = 1'b1;
              bc_idx    = BatchW'(head_r >> BOffW);
              res_nxt.granted_slot = head_r;
            end
          end
          ReqLookup, ReqRef, ReqForget: begin
            if (!live) begin
              res_nxt.status = StNotLive;
            end else if (req_r.req_type == ReqRef) begin
              we         = 1'b1;
              waddr      = s;
              wdata      = rdata;
              if (rdata.count != '1) begin
                wdata.count = rdata.count + 32'd1;
              end
            end else if (req_r.req_type == ReqForget && !is_static) begin
              we    = 1'b1;
              waddr = s;
              wdata = rdata;
              if (rdata.count > req_r.drop_count) begin
                wdata.count = rdata.count - req_r.drop_count;
              end else begin
                wdata.count   = '0;
                wdata.deleted = 1'b1;
                if (rdata.detached) begin
                  fr = 1'b1;
                end
              end
            end
          end
          ReqRetire: begin
            if (!alloc_ok) begin
              res_nxt.status = StNotLive;
            end else if (!is_static) begin
              we    = 1'b1;
              waddr = s;
              wdata = rdata;
              if (rdata.count == '0) begin
                fr = 1'b1;
              end else begin
                wdata.detached = 1'b1;
              end
            end
          end
          default: begin
            res_nxt.status = StNotLive;
          end
        endcase
        if (fr) begin
          // return the slot to the free list
          wdata      = '0;
          wdata.link = push_link;
          head_nxt   = s;
          bc_inc     = 1'b1;
          bc_idx     = sb;
          rel        = (sb != '0) && (cnt_after == BCntW'(BatchSize));
          res_nxt.slot_freed    = 1'b1;
          res_nxt.release_valid = rel;
          res_nxt.release_batch = rel ? 4'(sb) : 4'd0;
        end
        ov_nxt    = 1'b1;
        state_nxt = SOut;
      end
      SOut: begin
        state_nxt = SIdle;
      end
      default: begin
        state_nxt = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SClear;
      ptr_r        <= '0;
      head_r       <= '0;
      hw_r         <= '0;
      ov_r         <= 1'b0;
      grow_alloc_r <= 1'b0;
      grow_end_r   <= '0;
      for (int i = 0; i < NumBatches; i++) begin
        bcnt_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      head_r       <= head_nxt;
      hw_r         <= hw_nxt;
      ov_r         <= ov_nxt;
      grow_alloc_r <= grow_alloc_nxt;
      grow_end_r   <= grow_end_nxt;
      if (bc_inc && bcnt_r[bc_idx] < BCntW'(BatchSize)) begin
        bcnt_r[bc_idx] <= bcnt_r[bc_idx] + 1'b1;
      end else if (bc_dec && bcnt_r[bc_idx] != '0) begin
        bcnt_r[bc_idx] <= bcnt_r[bc_idx] - 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
  end

  assign busy      = (state_r != SIdle);
  assign out_valid = ov_r;
  assign out_word  = res_r;
endmodule

[design/rspa_slot_mem.sv]
// slot memory: one record per slot, one write and one registered read per cycle
module rspa_slot_mem
  import rspa_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [SlotW-1:0] waddr,
  input  slot_rec_t        wdata,
  input  logic             re,
  input  logic [SlotW-1:0] raddr,
  output slot_rec_t        rdata
);
  slot_rec_t mem [NumSlots];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[design/rspa_checker.sv]
// checker: port-level properties of the slot pool allocator, bound to the top level
module rspa_checker
  import rspa_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_word_t out_word
);
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after accept");
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result word longer than one cycle");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.status != 2'd3) else $error("bad status code");
  a_release_freed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.release_valid |-> out_word.slot_freed)
    else $error("release without free");
endmodule

bind refcounted_slot_pool_allocator rspa_checker u_rspa_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_word
);

[tb/rspa_checker.sv]
// checker: predicts each result word of the slot pool allocator and compares it
module rspa_scoreboard
  import rspa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  out_word_t out_word,
  output int        fail_count,
  output int        words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LinkW-1:0] link_mem [NumSlots];
  logic [31:0]      count_mem [NumSlots];
  logic             static_mem [NumSlots];
  logic             deleted_mem [NumSlots];
  logic             detached_mem [NumSlots];
  int               batch_free [NumBatches];
  int               head;
  int               high_water;
  out_word_t        expected_words [$];

  initial begin
    fail_count    = 0;
    words_pending = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic void stack_slot(input int s);
    link_mem[s] = (head != 0) ? LinkW'(head) : LinkEnd;
    head = s;
  endfunction

  function automatic void grow_batch();
    int top;
    if (high_water >= NumSlots) return;
    top = high_water + BatchSize;
    if (top > NumSlots) top = NumSlots;
    for (int i = high_water; i < top; i++) begin
      if (i == 0) continue;
      batch_free[i / BatchSize]++;
      stack_slot(i);
    end
    high_water = top;
  endfunction

  function automatic bit return_slot(input int s, output int b);
    b = s / BatchSize;
    count_mem[s] = '0;
    deleted_mem[s] = 1'b0;
    detached_mem[s] = 1'b0;
    if (batch_free[b] < BatchSize) batch_free[b]++;
    stack_slot(s);
    return b != 0 && batch_free[b] == BatchSize;
  endfunction

  function automatic bit slot_allocated(input int s);
    return s != 0 && s < high_water && link_mem[s] == '0;
  endfunction

  function automatic void clear_pool();
    for (int i = 0; i < NumSlots; i++) begin
      link_mem[i] = '0;
      count_mem[i] = '0;
      static_mem[i] = (i >= 1 && i < StaticSlots);
      deleted_mem[i] = 1'b0;
      detached_mem[i] = 1'b0;
    end
    for (int b = 0; b < NumBatches; b++) batch_free[b] = 0;
    head = 0;
    high_water = StaticSlots;
    grow_batch();
  endfunction

  function automatic out_word_t predict_word(input in_word_t w);
    out_word_t r;
    int s, g, b;
    bit rel;
    s = w.slot_index;
    r = '0;
    r.granted_slot = w.slot_index;
    r.status = StDone;
    rel = 1'b0;
    b = 0;
    case (w.req_type)
      ReqAlloc: begin
        r.granted_slot = '0;
        if (head == 0) grow_batch();
        if (head == 0) begin
          r.status = StExhausted;
        end else begin
          g = head;
          head = (link_mem[g] == LinkEnd) ? 0 : int'(link_mem[g]);
          if (batch_free[g / BatchSize] > 0) batch_free[g / BatchSize]--;
          link_mem[g] = '0;
          count_mem[g] = '0;
          deleted_mem[g] = 1'b0;
          detached_mem[g] = 1'b0;
          r.granted_slot = g[SlotW-1:0];
        end
      end
      ReqLookup, ReqRef, ReqForget: begin
        if (!slot_allocated(s) || deleted_mem[s]) begin
          r.status = StNotLive;
        end else if (w.req_type == ReqRef) begin
          if (count_mem[s] != '1) count_mem[s]++;
        end else if (w.req_type == ReqForget && !static_mem[s]) begin
          if (count_mem[s] > w.drop_count) begin
            count_mem[s] -= w.drop_count;
          end else begin
            count_mem[s] = '0;
            deleted_mem[s] = 1'b1;
            if (detached_mem[s]) begin
              rel = return_slot(s, b);
              r.slot_freed = 1'b1;
            end
          end
        end
      end
      ReqRetire: begin
        if (!slot_allocated(s)) begin
          r.status = StNotLive;
        end else if (!static_mem[s]) begin
          if (count_mem[s] == '0) begin
            rel = return_slot(s, b);
            r.slot_freed = 1'b1;
          end else begin
            detached_mem[s] = 1'b1;
          end
        end
      end
      default: r.status = StNotLive;
    endcase
    r.release_valid = rel;
    r.release_batch = rel ? b[3:0] : 4'd0;
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      clear_pool();
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (start && !busy) expected_words.push_back(predict_word(in_word));
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, status", out_word.status, 0);
        end else begin
          want = expected_words.pop_front();
          if (out_word.status != want.status)
            report_mismatch("status", out_word.status, want.status);
          if (out_word.granted_slot != want.granted_slot)
            report_mismatch("granted_slot", out_word.granted_slot, want.granted_slot);
          if (out_word.slot_freed != want.slot_freed)
            report_mismatch("slot_freed", out_word.slot_freed, want.slot_freed);
          if (out_word.release_valid != want.release_valid)
            report_mismatch("release_valid", out_word.release_valid, want.release_valid);
          if (out_word.release_batch != want.release_batch)
            report_mismatch("release_batch", out_word.release_batch, want.release_batch);
        end
      end
    end
    words_pending = expected_words.size();
  end
endmodule

[tb/testbench.sv]
// testbench top: request stimulus, clock, reset, watchdog and verdict
module testbench;
  import rspa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // the quiet-cycle limit covers both a batch growth and the reset clearing
  // pass with the growth of the first batch that follows it
  localparam int QuietLimit = 4 * (NumSlots + BatchSize) + 200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;
  int        fail_count;
  int        words_pending;
  int        quiet_cycles = 0;
  int        live_slots [$];   // slots named by done words that freed nothing, as far as the tb knows

  always #5 clk = ~clk;

  refcounted_slot_pool_allocator i_dut (
    .clk, .rst_n, .start, .busy, .in_word, .out_valid, .out_word
  );

  rspa_scoreboard i_checker (
    .clk, .rst_n, .start, .busy, .in_word, .out_valid, .out_word,
    .fail_count, .words_pending
  );

  // watchdog: counts cycles with no word accepted on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // note the slot of each done word that freed nothing, alloc grants among them, so later requests hit live slots
  always @(posedge clk) begin
    if (rst_n && out_valid && out_word.status == StDone && out_word.granted_slot != 0 &&
        !out_word.slot_freed)
      live_slots.push_back(out_word.granted_slot);
  end

  // present one request word, hold it until it is accepted, then drop start
  // while the block is busy anyway
  task automatic send_word(input logic [2:0] kind, input logic [13:0] slot,
                           input logic [31:0] drop);
    start <= 1'b1;
    in_word <= '{req_type: kind, slot_index: slot, drop_count: drop};
    do @(posedge clk); while (busy);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic idle_burst(input bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 16)) @(posedge clk);
  endtask

  function automatic logic [13:0] pick_slot();
    case ($urandom_range(0, 9))
      0: return 14'($urandom);
      1: return 14'($urandom_range(0, StaticSlots));
      2: return 14'(NumSlots - 1 - $urandom_range(0, 3));
      default: return (live_slots.size() == 0) ? 14'd1000 :
                      14'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
    endcase
  endfunction

  function automatic logic [31:0] pick_drop();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return 32'($urandom_range(1, 3));
    endcase
  endfunction

  initial begin
    logic [2:0] kind;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: each request kind, null handle, statics, edges of the fields
    send_word(ReqAlloc, 14'd0, 32'd0);
    send_word(ReqAlloc, 14'd0, 32'd0);
    send_word(ReqLookup, 14'd1023, 32'd0);
    send_word(ReqRef, 14'd1023, 32'd0);
    send_word(ReqRef, 14'd1023, 32'd0);
    send_word(ReqForget, 14'd1023, 32'd1);
    send_word(ReqRetire, 14'd1023, 32'd0);      // slot still on the free list, so not live
    send_word(ReqForget, 14'd1023, 32'hFFFF_FFFF); // not live, nothing freed
    send_word(ReqForget, 14'd1022, 32'd0);      // slot not allocated, so not live
    send_word(ReqLookup, 14'd1022, 32'd0);      // still free, not live
    send_word(ReqRetire, 14'd1022, 32'd0);      // free slot, not live, nothing freed
    send_word(ReqLookup, 14'd0, 32'd0);
    send_word(ReqRetire, 14'd0, 32'd0);
    send_word(ReqForget, 14'd3, 32'd5);         // static slot
    send_word(ReqRetire, 14'd7, 32'd0);
    send_word(ReqRef, 14'd16383, 32'hAAAA_5555);
    send_word(ReqLookup, 14'h2AAA, 32'h5555_AAAA);
    send_word(3'd5, 14'h1555, 32'd0);
    send_word(3'd6, 14'd0, 32'd0);
    send_word(3'd7, 14'h3FFF, 32'hFFFF_FFFF);

    // pause until the block has drained every outstanding word
    wait (words_pending == 0);
    @(posedge clk);

    // random: mostly allocs and requests on known slots, no idle gaps near the end
    for (int n = 0; n < 550; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: kind = ReqAlloc;
        5, 6:          kind = ReqLookup;
        7, 8, 9, 10:   kind = ReqRef;
        11, 12, 13, 14: kind = ReqForget;
        15, 16, 17, 18: kind = ReqRetire;
        default:       kind = 3'($urandom_range(5, 7));
      endcase
      send_word(kind, pick_slot(), pick_drop());
      idle_burst(n < 450);
    end

    wait (words_pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[filelist.f]
design/rspa_pkg.sv
design/rspa_slot_mem.sv
design/refcounted_slot_pool_allocator.sv
design/rspa_checker.sv
tb/rspa_checker.sv
tb/testbench.sv
